/* src/pmqi_pkg.sv */
// ----------------------------------------------------------------------------
// pmqi_pkg
// Shared types and constants for the PIA mouse quadrature interface core.
// ----------------------------------------------------------------------------
package pmqi_pkg;

    // widths of the pending movement counters and the ROM address
    localparam int DELTA_BITS   = 16;
    localparam int PAGE_BITS    = 3;
    localparam int OFFSET_BITS  = 8;
    localparam int ROM_ADDR_BITS = PAGE_BITS + OFFSET_BITS;
    localparam int POS_BITS     = 10;
    localparam int DIFF_BITS    = POS_BITS + 1;

    // control register bit that picks data (1) or direction (0)
    localparam int SEL_DATA_BIT = 2;

    // position after reset
    localparam logic [POS_BITS-1:0] POS_RESET = POS_BITS'(512);

    // quadrature read byte bits
    localparam int QBIT_X_MOVE  = 0;
    localparam int QBIT_X_DIR   = 1;
    localparam int QBIT_Y_DIR   = 2;
    localparam int QBIT_Y_MOVE  = 3;
    localparam int QBIT_BTN_N   = 7;

    // bus commands
    typedef enum logic [2:0] {
        CMD_READ   = 3'd0,
        CMD_WRITE  = 3'd1,
        CMD_ROM    = 3'd2,
        CMD_SETPOS = 3'd3,
        CMD_SETBTN = 3'd4
    } cmd_t;

    // PIA register select
    typedef enum logic [1:0] {
        REG_DATA_A = 2'd0,
        REG_CTRL_A = 2'd1,
        REG_DATA_B = 2'd2,
        REG_CTRL_B = 2'd3
    } reg_sel_t;

    // one input item
    typedef struct packed {
        logic [2:0]          command;
        reg_sel_t            reg_index;
        logic [7:0]          write_data;
        logic [OFFSET_BITS-1:0] page_offset;
        logic [POS_BITS-1:0] new_x;
        logic [POS_BITS-1:0] new_y;
        logic                button_pressed;
    } item_t;

    // one result item
    typedef struct packed {
        logic [7:0]               read_data;
        logic [ROM_ADDR_BITS-1:0] rom_address;
        logic [POS_BITS-1:0]      pos_x;
        logic [POS_BITS-1:0]      pos_y;
        logic                     button_state;
    } result_t;

endpackage

/* src/pmqi_in_stage.sv */
// ----------------------------------------------------------------------------
// pmqi_in_stage
// Input register: captures one item from the slave side, holds it while the
// engine cannot take it.
// ----------------------------------------------------------------------------
module pmqi_in_stage
    import pmqi_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  item_t item_in,
    input  logic  take,
    output logic  valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // free when empty or when the held item leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_in;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

/* src/pmqi_engine.sv */
// ----------------------------------------------------------------------------
// pmqi_engine
// PIA registers, mouse position and pending deltas; builds the result of one
// item and commits the state update when the item moves on.
// ----------------------------------------------------------------------------
module pmqi_engine
    import pmqi_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    output result_t res
);

    localparam logic signed [DELTA_BITS-1:0] DELTA_MAX = {1'b0, {(DELTA_BITS-1){1'b1}}};
    localparam logic signed [DELTA_BITS-1:0] DELTA_MIN = {1'b1, {(DELTA_BITS-1){1'b0}}};

    logic [7:0] ctrl_a_reg, ctrl_b_reg, dir_a_reg, dir_b_reg, out_b_reg;
    logic [7:0] ctrl_a_next, ctrl_b_next, dir_a_next, dir_b_next, out_b_next;
    logic [POS_BITS-1:0] pos_x_reg, pos_y_reg, pos_x_next, pos_y_next;
    logic btn_reg, btn_next;
    logic signed [DELTA_BITS-1:0] pdx_reg, pdy_reg, pdx_next, pdy_next;

    logic [7:0] quad_byte;
    logic [7:0] read_byte;
    logic signed [DELTA_BITS-1:0] pdx_step, pdy_step, pdx_sat, pdy_sat;
    logic quad_read;

    // saturating add of a position difference to a pending delta
    function automatic logic signed [DELTA_BITS-1:0] sat_add(
        input logic signed [DELTA_BITS-1:0] acc,
        input logic [POS_BITS-1:0]          new_pos,
        input logic [POS_BITS-1:0]          old_pos
    );
        logic signed [DIFF_BITS-1:0]  diff;
        logic signed [DELTA_BITS:0]   sum;
        logic signed [DELTA_BITS-1:0] r;
        diff = signed'({1'b0, new_pos}) - signed'({1'b0, old_pos});
        sum  = (DELTA_BITS+1)'(acc) + (DELTA_BITS+1)'(diff);
        if (sum[DELTA_BITS] != sum[DELTA_BITS-1])
        begin
            r = sum[DELTA_BITS] ? DELTA_MIN : DELTA_MAX;
        end
        else
        begin
            r = sum[DELTA_BITS-1:0];
        end
        return r;
    endfunction

    // one unit toward zero
    function automatic logic signed [DELTA_BITS-1:0] toward_zero(
        input logic signed [DELTA_BITS-1:0] d
    );
        logic signed [DELTA_BITS-1:0] r;
        if (d == '0)
        begin
            r = d;
        end
        else if (d[DELTA_BITS-1])
        begin
            r = d + DELTA_BITS'(1);
        end
        else
        begin
            r = d - DELTA_BITS'(1);
        end
        return r;
    endfunction

    // quadrature step byte from the current deltas and button
    always_comb
    begin
        quad_byte              = '0;
        quad_byte[QBIT_X_MOVE] = (pdx_reg != '0);
        quad_byte[QBIT_X_DIR]  = (pdx_reg != '0) && !pdx_reg[DELTA_BITS-1];
        quad_byte[QBIT_Y_MOVE] = (pdy_reg != '0);
        quad_byte[QBIT_Y_DIR]  = (pdy_reg != '0) && !pdy_reg[DELTA_BITS-1];
        quad_byte[QBIT_BTN_N]  = !btn_reg;
    end

    assign pdx_step = toward_zero(pdx_reg);
    assign pdy_step = toward_zero(pdy_reg);
    assign pdx_sat  = sat_add(pdx_reg, item.new_x, pos_x_reg);
    assign pdy_sat  = sat_add(pdy_reg, item.new_y, pos_y_reg);

    // register read mux
    always_comb
    begin
        quad_read = 1'b0;
        unique case (item.reg_index)
            REG_DATA_A:
            begin
                quad_read = ctrl_a_reg[SEL_DATA_BIT];
                read_byte = ctrl_a_reg[SEL_DATA_BIT] ? quad_byte : dir_a_reg;
            end
            REG_CTRL_A: read_byte = ctrl_a_reg;
            REG_DATA_B: read_byte = ctrl_b_reg[SEL_DATA_BIT] ? out_b_reg : dir_b_reg;
            REG_CTRL_B: read_byte = ctrl_b_reg;
            default:    read_byte = ctrl_b_reg;
        endcase
    end

    // command decode: next state and result fields
    always_comb
    begin
        ctrl_a_next = ctrl_a_reg;
        ctrl_b_next = ctrl_b_reg;
        dir_a_next  = dir_a_reg;
        dir_b_next  = dir_b_reg;
        out_b_next  = out_b_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        btn_next    = btn_reg;
        pdx_next    = pdx_reg;
        pdy_next    = pdy_reg;
        res.read_data   = '0;
        res.rom_address = '0;
        unique case (item.command)
            CMD_READ:
            begin
                res.read_data = read_byte;
                if (quad_read)
                begin
                    pdx_next = pdx_step;
                    pdy_next = pdy_step;
                end
            end
            CMD_WRITE:
            begin
                unique case (item.reg_index)
                    REG_DATA_A:
                    begin
                        if (!ctrl_a_reg[SEL_DATA_BIT])
                        begin
                            dir_a_next = item.write_data;
                        end
                    end
                    REG_CTRL_A: ctrl_a_next = item.write_data;
                    REG_DATA_B:
                    begin
                        if (ctrl_b_reg[SEL_DATA_BIT])
                        begin
                            out_b_next = item.write_data;
                        end
                        else
                        begin
                            dir_b_next = item.write_data;
                        end
                    end
                    default: ctrl_b_next = item.write_data;
                endcase
            end
            CMD_ROM:
            begin
                res.rom_address = {out_b_reg[PAGE_BITS-1:0], item.page_offset};
            end
            CMD_SETPOS:
            begin
                pdx_next   = pdx_sat;
                pdy_next   = pdy_sat;
                pos_x_next = item.new_x;
                pos_y_next = item.new_y;
            end
            CMD_SETBTN: btn_next = item.button_pressed;
            default:
            begin
                btn_next = btn_reg;
            end
        endcase
        res.pos_x        = pos_x_next;
        res.pos_y        = pos_y_next;
        res.button_state = btn_next;
    end

    // state commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_a_reg <= '0;
            ctrl_b_reg <= '0;
            dir_a_reg  <= '0;
            dir_b_reg  <= '0;
            out_b_reg  <= '0;
            pos_x_reg  <= POS_RESET;
            pos_y_reg  <= POS_RESET;
            btn_reg    <= 1'b0;
            pdx_reg    <= '0;
            pdy_reg    <= '0;
        end
        else if (fire)
        begin
            ctrl_a_reg <= ctrl_a_next;
            ctrl_b_reg <= ctrl_b_next;
            dir_a_reg  <= dir_a_next;
            dir_b_reg  <= dir_b_next;
            out_b_reg  <= out_b_next;
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            btn_reg    <= btn_next;
            pdx_reg    <= pdx_next;
            pdy_reg    <= pdy_next;
        end
    end

    // state only moves with an item
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(pdx_reg) && $stable(pdy_reg) && $stable(pos_x_reg)
                  && $stable(pos_y_reg))
        else $error("state changed without an item");

    // a quadrature read walks a positive x delta down by one
    a_quad_step: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.command == CMD_READ && quad_read && pdx_reg > 0
        |=> pdx_reg == $past(pdx_reg) - DELTA_BITS'(1))
        else $error("quadrature read did not step x delta");

    // read data only for register reads, rom address only for rom reads
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.command != CMD_READ && item.command != CMD_ROM
        |-> res.read_data == '0 && res.rom_address == '0)
        else $error("result fields not cleared");

endmodule

/* src/pmqi_out_stage.sv */
// ----------------------------------------------------------------------------
// pmqi_out_stage
// Result register on the master side; holds a result while the receiver
// stalls.
// ----------------------------------------------------------------------------
module pmqi_out_stage
    import pmqi_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load_valid,
    output logic    load_ready,
    input  result_t load_res,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign load_ready = !valid_reg || m_tready;
    assign valid_next = (load_valid && load_ready) || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result capture
    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            res_reg <= load_res;
        end
    end

    assign m_tvalid = valid_reg;
    assign res      = res_reg;

endmodule

/* src/pia_mouse_quadrature_interface_core.sv */
// ----------------------------------------------------------------------------
// pia_mouse_quadrature_interface_core
// Mouse interface card around a four-register PIA, one bus command per item.
// ----------------------------------------------------------------------------
// Usage:
//   slave side carries commands: tuser holds the command code (read, write,
//   slot rom read, set position, set button), tdata the operands.
//   master side returns one result item per command: read byte, rom address,
//   stored position and button after the command.
// Path: an accepted item passes the input register and the decode, and its
//   result is held in the result register that drives m_tvalid.
// Throughput: one item per cycle unless m_tready stalls; the state update of an
//   item is committed in the same cycle it is decoded, so the next item sees it directly.
// Reset: PIA registers, button and pending deltas clear, position goes to
//   the middle of the range (512, 512); both stages empty.
// Stall: the result register holds while m_tready is low, one more item
//   waits in the input register, then s_tready drops.
// ----------------------------------------------------------------------------
module pia_mouse_quadrature_interface_core
    import pmqi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // command
    input  logic [39:0] s_tdata,   // reg_index, write_data, page_offset, new_x, new_y,
                                   // button_pressed, zero pad
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // read_data, rom_address, pos_x, pos_y, button_state
);

    item_t   item_in;
    item_t   item;
    logic    item_valid;
    logic    out_ready;
    logic    fire;
    result_t res_comb;
    result_t res_out;

    // unpack slave side
    always_comb
    begin
        item_in.command        = s_tuser;
        item_in.reg_index      = reg_sel_t'(s_tdata[1:0]);
        item_in.write_data     = s_tdata[9:2];
        item_in.page_offset    = s_tdata[17:10];
        item_in.new_x          = s_tdata[27:18];
        item_in.new_y          = s_tdata[37:28];
        item_in.button_pressed = s_tdata[38];
    end

    assign fire = item_valid && out_ready;

    pmqi_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .item_in  (item_in),
        .take     (fire),
        .valid    (item_valid),
        .item     (item)
    );

    pmqi_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item),
        .res   (res_comb)
    );

    pmqi_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (item_valid),
        .load_ready (out_ready),
        .load_res   (res_comb),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .res        (res_out)
    );

    // pack master side
    assign m_tdata = {res_out.button_state, res_out.pos_y, res_out.pos_x,
                      res_out.rom_address, res_out.read_data};

endmodule
